/* rtl/ssp_pkg.sv */
// Shared types and constants for the sprite screen projection pipeline.
// No dependencies; the other files that use it refer to this package by scoped names.
package ssp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CAMERA_X     = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
    localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_VIEW_PLANE_X = 3'd4;
    localparam logic [2:0] REG_VIEW_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_SCREEN_W     = 3'd6;
    localparam logic [2:0] REG_SCREEN_H     = 3'd7;

    // Register reset values
    localparam logic signed [15:0] RST_CAMERA_X     = 16'sd0;
    localparam logic signed [15:0] RST_CAMERA_Y     = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_DIR_X   = 16'sd16384;
    localparam logic signed [15:0] RST_VIEW_DIR_Y   = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_PLANE_X = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_PLANE_Y = 16'sd10813;
    localparam logic [12:0]        RST_SCREEN_W     = 13'd640;
    localparam logic [12:0]        RST_SCREEN_H     = 13'd480;

    // Fraction bits of the direction and plane vectors
    localparam int VEC_BITS = 14;

    // Magnitude widths of the camera transform
    localparam int MAG_W = 33;   // |numerator| and |det|
    localparam int T_QW  = 47;   // quotient bits of tx / ty
    localparam int C_QW  = 17;   // quotient bits of center and size

    // Output bus layout
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 120;

    // Front end result: magnitudes and signs of the transform terms
    typedef struct packed {
        logic              valid;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic [MAG_W-1:0]  mag_det;
        logic              sign_x;
        logic              sign_y;
        logic              det_zero;
    } ssp_front_t;

    // Flags and depth that travel beside the center and size division
    typedef struct packed {
        logic               visible;
        logic               neg;
        logic               ovf_c;
        logic               ovf_s;
        logic signed [15:0] depth;
    } ssp_side_t;

    // Input of the bounds stage
    typedef struct packed {
        logic              valid;
        ssp_side_t         side;
        logic [C_QW-1:0]   q_c;
        logic [C_QW-1:0]   q_s;
    } ssp_proj_t;

endpackage

/* rtl/ssp_udiv.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; carries a sideband word in step with the data.
module ssp_udiv #(
    parameter int DW = 47,
    parameter int VW = 33,
    parameter int QW = 47,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,   // must stay below divisor << QW
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [QW];
    logic [VW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [VW-1:0] dv_reg   [QW];
    logic [SW-1:0] sd_reg   [QW];

    logic          vld_src  [QW];
    logic [VW-1:0] rem_src  [QW];
    logic [QW-1:0] low_src  [QW];
    logic [QW-1:0] q_src    [QW];
    logic [VW-1:0] dv_src   [QW];
    logic [SW-1:0] sd_src   [QW];

    logic [VW-1:0] rem_next [QW];
    logic [QW-1:0] low_next [QW];
    logic [QW-1:0] q_next   [QW];

    // Stage sources: the inputs feed the first step
    always_comb begin
        vld_src[0] = in_valid;
        rem_src[0] = VW'(dividend >> QW);
        low_src[0] = QW'(dividend);
        q_src[0]   = '0;
        dv_src[0]  = divisor;
        sd_src[0]  = in_side;
        for (int k = 1; k < QW; k++) begin
            vld_src[k] = vld_reg[k-1];
            rem_src[k] = rem_reg[k-1];
            low_src[k] = low_reg[k-1];
            q_src[k]   = q_reg[k-1];
            dv_src[k]  = dv_reg[k-1];
            sd_src[k]  = sd_reg[k-1];
        end
    end

    // One trial subtract per stage
    always_comb begin
        logic [VW:0] trial;
        logic [VW:0] diff;
        for (int k = 0; k < QW; k++) begin
            trial       = {rem_src[k], low_src[k][QW-1]};
            diff        = trial - {1'b0, dv_src[k]};
            rem_next[k] = (trial >= {1'b0, dv_src[k]}) ? VW'(diff) : VW'(trial);
            low_next[k] = low_src[k] << 1;
            q_next[k]   = {q_src[k][QW-2:0], (trial >= {1'b0, dv_src[k]})};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < QW; k++) vld_reg[k] <= vld_src[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                q_reg[k]   <= q_next[k];
                dv_reg[k]  <= dv_src[k];
                sd_reg[k]  <= sd_src[k];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign out_side  = sd_reg[QW-1];

endmodule

/* rtl/ssp_front.sv */
// Camera transform front end: relative position, products, numerators, magnitudes.
// Depends on ssp_pkg.
module ssp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] camera_x,
    input  logic signed [15:0] camera_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] plane_x,
    input  logic signed [15:0] plane_y,
    output ssp_pkg::ssp_front_t front
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [16:0] rx_reg, ry_reg;
    logic signed [32:0] dyrx_reg, dxry_reg, pxry_reg, pyrx_reg;
    logic signed [31:0] pxdy_reg, dxpy_reg;
    logic signed [33:0] numx_reg, numy_reg, det_reg;
    logic [ssp_pkg::MAG_W-1:0] magx_reg, magy_reg, magd_reg;
    logic               sx_reg, sy_reg, dz_reg;

    logic signed [33:0] numx_next, numy_next, det_next;
    logic signed [33:0] absx_next, absy_next, absd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Numerators and determinant, then magnitudes
    assign numx_next = 34'(dyrx_reg) - 34'(dxry_reg);
    assign numy_next = 34'(pxry_reg) - 34'(pyrx_reg);
    assign det_next  = 34'(pxdy_reg) - 34'(dxpy_reg);
    assign absx_next = numx_reg[33] ? -numx_reg : numx_reg;
    assign absy_next = numy_reg[33] ? -numy_reg : numy_reg;
    assign absd_next = det_reg[33]  ? -det_reg  : det_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // relative position
            rx_reg   <= 17'(pos_x) - 17'(camera_x);
            ry_reg   <= 17'(pos_y) - 17'(camera_y);
            // products
            dyrx_reg <= dir_y * rx_reg;
            dxry_reg <= dir_x * ry_reg;
            pxry_reg <= plane_x * ry_reg;
            pyrx_reg <= plane_y * rx_reg;
            pxdy_reg <= plane_x * dir_y;
            dxpy_reg <= dir_x * plane_y;
            // differences
            numx_reg <= numx_next;
            numy_reg <= numy_next;
            det_reg  <= det_next;
            // magnitudes and quotient signs
            magx_reg <= absx_next[ssp_pkg::MAG_W-1:0];
            magy_reg <= absy_next[ssp_pkg::MAG_W-1:0];
            magd_reg <= absd_next[ssp_pkg::MAG_W-1:0];
            sx_reg   <= numx_reg[33] ^ det_reg[33];
            sy_reg   <= numy_reg[33] ^ det_reg[33];
            dz_reg   <= (det_reg == '0);
        end
    end

    assign front.valid    = v4_reg;
    assign front.mag_x    = magx_reg;
    assign front.mag_y    = magy_reg;
    assign front.mag_det  = magd_reg;
    assign front.sign_x   = sx_reg;
    assign front.sign_y   = sy_reg;
    assign front.det_zero = dz_reg;

endmodule

/* rtl/ssp_bounds.sv */
// Output stages: center and size saturation, then column and row bounds.
// Depends on ssp_pkg.
module ssp_bounds (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  ssp_pkg::ssp_proj_t proj,
    input  logic [12:0]        screen_width,
    input  logic [12:0]        screen_height,
    output logic               out_valid,
    output logic               visible,
    output logic signed [15:0] depth,
    output logic signed [16:0] center_column,
    output logic [15:0]        sprite_size,
    output logic signed [16:0] first_column,
    output logic signed [16:0] last_column,
    output logic signed [16:0] first_row,
    output logic signed [16:0] last_row
);

    logic               v1_reg, v2_reg;
    logic               vis1_reg, vis2_reg;
    logic signed [15:0] dep1_reg, dep2_reg;
    logic signed [16:0] ctr1_reg, ctr2_reg;
    logic signed [17:0] cfull1_reg;
    logic [15:0]        size1_reg, size2_reg;
    logic signed [16:0] fc_reg, lc_reg, fr_reg, lr_reg;

    logic signed [17:0] qc_s;
    logic signed [17:0] cfull_next;
    logic signed [16:0] ctr_next;
    logic [15:0]        size_next;
    logic signed [18:0] half, w19, h19, hh19, fc_w, lc_w, fr_w, lr_w;
    logic signed [16:0] fc_next, lc_next, fr_next, lr_next;

    // Center column and size with saturation
    always_comb begin
        qc_s = $signed({1'b0, proj.q_c});
        // unsaturated center; an overflowed quotient stands in as the widest value
        if (!proj.side.visible) begin
            cfull_next = '0;
        end else if (proj.side.ovf_c) begin
            cfull_next = proj.side.neg ? $signed({1'b1, 17'd0}) : 18'sd131071;
        end else if (proj.side.neg) begin
            cfull_next = -qc_s;
        end else begin
            cfull_next = qc_s;
        end
        if (cfull_next > 18'sd65535) begin
            ctr_next = 17'sd65535;
        end else if (cfull_next < -18'sd65536) begin
            ctr_next = -17'sd65536;
        end else begin
            ctr_next = 17'(cfull_next);
        end
        if (!proj.side.visible || proj.side.ovf_s || proj.q_s > 17'd65535) begin
            size_next = 16'hFFFF;
        end else begin
            size_next = proj.q_s[15:0];
        end
    end

    // Columns from unsaturated center, rows from H/2, clamped on one side each
    always_comb begin
        half = $signed({4'b0, size1_reg[15:1]});
        w19  = $signed({6'b0, screen_width});
        h19  = $signed({6'b0, screen_height});
        hh19 = $signed({7'b0, screen_height[12:1]});
        fc_w = 19'(cfull1_reg) - half;
        lc_w = 19'(cfull1_reg) + half;
        fr_w = hh19 - half;
        lr_w = hh19 + half;
        if (fc_w < 0) fc_w = '0;
        if (lc_w >= w19) lc_w = w19 - 19'sd1;
        if (fr_w < 0) fr_w = '0;
        if (lr_w >= h19) lr_w = h19 - 19'sd1;
        if (!vis1_reg) begin
            fc_w = '0;
            lc_w = w19 - 19'sd1;
            fr_w = '0;
            lr_w = h19 - 19'sd1;
        end
        fc_next = (fc_w > 19'sd65535) ? 17'sd65535 : 17'(fc_w);
        fr_next = 17'(fr_w);
        lr_next = 17'(lr_w);
        lc_next = (lc_w < -19'sd65536) ? -17'sd65536 : 17'(lc_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= proj.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis1_reg   <= proj.side.visible;
            dep1_reg   <= proj.side.depth;
            ctr1_reg   <= ctr_next;
            cfull1_reg <= cfull_next;
            size1_reg  <= size_next;
            vis2_reg   <= vis1_reg;
            dep2_reg   <= dep1_reg;
            ctr2_reg   <= ctr1_reg;
            size2_reg  <= size1_reg;
            fc_reg     <= fc_next;
            lc_reg     <= lc_next;
            fr_reg     <= fr_next;
            lr_reg     <= lr_next;
        end
    end

    assign out_valid     = v2_reg;
    assign visible       = vis2_reg;
    assign depth         = dep2_reg;
    assign center_column = ctr2_reg;
    assign sprite_size   = size2_reg;
    assign first_column  = fc_reg;
    assign last_column   = lc_reg;
    assign first_row     = fr_reg;
    assign last_row      = lr_reg;

endmodule

/* rtl/sprite_screen_projection.sv */
// Sprite screen projection, top level: config registers, dividers, glue stages.
// Depends on ssp_pkg, ssp_front, ssp_udiv and ssp_bounds.
//
// Projects one sprite position per item into screen space. The block is a
// fully pipelined datapath that accepts one item every clock cycle unless the
// output stalls. Each item passes through 4 front-end stages, 47 stages of the
// bit-per-stage tx/ty divider, 6 scaling stages, 17 stages of the center/size
// divider and 2 bounds stages; the tx/ty divider is the longest of these.
// A stall on the output freezes the whole pipeline, nothing lost.
// Configuration writes are taken at any time and must happen while the pipe
// holds no item; cfg_ready is always high.
module sprite_screen_projection #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ssp_pkg::S_TDATA_W-1:0]    s_tdata,  // sprite_pos_x, sprite_pos_y
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // depth, center_column, sprite_size, first_column, last_column,
    // first_row, last_row, 3 zero bits
    output logic [ssp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tuser   // visible
);

    localparam int DSW  = 13 + FRAC_BITS;
    localparam int SIDW = $bits(ssp_pkg::ssp_side_t);

    logic signed [15:0] cam_x_reg, cam_y_reg, dir_x_reg, dir_y_reg;
    logic signed [15:0] pl_x_reg, pl_y_reg;
    logic [12:0]        width_reg, height_reg;

    logic en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg  <= ssp_pkg::RST_CAMERA_X;
            cam_y_reg  <= ssp_pkg::RST_CAMERA_Y;
            dir_x_reg  <= ssp_pkg::RST_VIEW_DIR_X;
            dir_y_reg  <= ssp_pkg::RST_VIEW_DIR_Y;
            pl_x_reg   <= ssp_pkg::RST_VIEW_PLANE_X;
            pl_y_reg   <= ssp_pkg::RST_VIEW_PLANE_Y;
            width_reg  <= ssp_pkg::RST_SCREEN_W;
            height_reg <= ssp_pkg::RST_SCREEN_H;
        end else if (cfg_valid) begin
            case (cfg_index)
                ssp_pkg::REG_CAMERA_X:     cam_x_reg  <= cfg_data;
                ssp_pkg::REG_CAMERA_Y:     cam_y_reg  <= cfg_data;
                ssp_pkg::REG_VIEW_DIR_X:   dir_x_reg  <= cfg_data;
                ssp_pkg::REG_VIEW_DIR_Y:   dir_y_reg  <= cfg_data;
                ssp_pkg::REG_VIEW_PLANE_X: pl_x_reg   <= cfg_data;
                ssp_pkg::REG_VIEW_PLANE_Y: pl_y_reg   <= cfg_data;
                ssp_pkg::REG_SCREEN_W:     width_reg  <= cfg_data[12:0];
                ssp_pkg::REG_SCREEN_H:     height_reg <= cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Whole pipeline advances when the output register is free or taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ssp_pkg::ssp_front_t front;

    ssp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .pos_x    (s_tdata[15:0]),
        .pos_y    (s_tdata[31:16]),
        .camera_x (cam_x_reg),
        .camera_y (cam_y_reg),
        .dir_x    (dir_x_reg),
        .dir_y    (dir_y_reg),
        .plane_x  (pl_x_reg),
        .plane_y  (pl_y_reg),
        .front    (front)
    );

    // tx and ty = |num| * 2^14 / |det|
    logic                      tv;
    logic [ssp_pkg::T_QW-1:0]  qx, qy;
    logic                      sx_d;
    logic [1:0]                syz_d;

    ssp_udiv #(.DW(ssp_pkg::T_QW), .VW(ssp_pkg::MAG_W), .QW(ssp_pkg::T_QW), .SW(1)) u_div_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front.valid),
        .dividend  ({front.mag_x, ssp_pkg::VEC_BITS'(0)}),
        .divisor   (front.mag_det),
        .in_side   (front.sign_x),
        .out_valid (),
        .quot      (qx),
        .out_side  (sx_d)
    );

    ssp_udiv #(.DW(ssp_pkg::T_QW), .VW(ssp_pkg::MAG_W), .QW(ssp_pkg::T_QW), .SW(2)) u_div_ty (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front.valid),
        .dividend  ({front.mag_y, ssp_pkg::VEC_BITS'(0)}),
        .divisor   (front.mag_det),
        .in_side   ({front.sign_y, front.det_zero}),
        .out_valid (tv),
        .quot      (qy),
        .out_side  (syz_d)
    );

    // Scaling stages G1..G6
    logic               g1_v_reg, g2_v_reg, g3_v_reg, g4_v_reg, g5_v_reg, g6_v_reg;
    logic               vis1_reg, vis2_reg, vis3_reg, vis4_reg, vis5_reg, vis6_reg;
    logic signed [47:0] tx_reg, ty1_reg, ty2_reg, ty3_reg, ty4_reg, ty5_reg, ty6_reg;
    logic signed [48:0] sum_reg;
    logic signed [15:0] dep2_reg, dep3_reg, dep4_reg, dep5_reg, dep6_reg;
    logic signed [38:0] plo_reg;
    logic signed [36:0] phi_reg;
    logic signed [61:0] n_reg;
    logic [60:0]        nmag_reg, nmag6_reg;
    logic               neg5_reg, neg6_reg;
    logic               ovc_reg, ovs_reg;

    logic signed [47:0] tx_next, ty_next;
    logic signed [15:0] dep_next;
    logic signed [12:0] w2;
    logic signed [61:0] nabs;
    logic [DSW-1:0]     ds;
    logic [63:0]        ty_sh;

    always_comb begin
        tx_next = sx_d     ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ty_next = syz_d[1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        if (syz_d[0]) begin
            tx_next = '0;
            ty_next = '0;
        end
        if (ty1_reg > 48'sd32767) begin
            dep_next = 16'sd32767;
        end else if (ty1_reg < -48'sd32768) begin
            dep_next = -16'sd32768;
        end else begin
            dep_next = 16'(ty1_reg);
        end
    end

    assign w2    = $signed({1'b0, width_reg[12:1]});
    assign nabs  = n_reg[61] ? -n_reg : n_reg;
    assign ds    = {height_reg, FRAC_BITS'(0)};
    assign ty_sh = {ty5_reg[46:0], 17'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_v_reg <= 1'b0;
            g2_v_reg <= 1'b0;
            g3_v_reg <= 1'b0;
            g4_v_reg <= 1'b0;
            g5_v_reg <= 1'b0;
            g6_v_reg <= 1'b0;
        end else if (en) begin
            g1_v_reg <= tv;
            g2_v_reg <= g1_v_reg;
            g3_v_reg <= g2_v_reg;
            g4_v_reg <= g3_v_reg;
            g5_v_reg <= g4_v_reg;
            g6_v_reg <= g5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // G1: signed tx, ty, visibility
            tx_reg    <= tx_next;
            ty1_reg   <= ty_next;
            vis1_reg  <= !syz_d[0] && !syz_d[1] && (qy != '0);
            // G2: ty + tx, saturated depth
            sum_reg   <= 49'(tx_reg) + 49'(ty1_reg);
            ty2_reg   <= ty1_reg;
            vis2_reg  <= vis1_reg;
            dep2_reg  <= dep_next;
            // G3: (W/2) * sum as two partial products
            plo_reg   <= w2 * $signed({1'b0, sum_reg[24:0]});
            phi_reg   <= w2 * $signed(sum_reg[48:25]);
            ty3_reg   <= ty2_reg;
            vis3_reg  <= vis2_reg;
            dep3_reg  <= dep2_reg;
            // G4: combine partial products
            n_reg     <= (62'(phi_reg) <<< 25) + 62'(plo_reg);
            ty4_reg   <= ty3_reg;
            vis4_reg  <= vis3_reg;
            dep4_reg  <= dep3_reg;
            // G5: magnitude of the center numerator
            nmag_reg  <= nabs[60:0];
            neg5_reg  <= n_reg[61];
            ty5_reg   <= ty4_reg;
            vis5_reg  <= vis4_reg;
            dep5_reg  <= dep4_reg;
            // G6: quotient range checks
            ovc_reg   <= {3'b0, nmag_reg} >= ty_sh;
            ovs_reg   <= 64'(ds) >= ty_sh;
            nmag6_reg <= nmag_reg;
            neg6_reg  <= neg5_reg;
            ty6_reg   <= ty5_reg;
            vis6_reg  <= vis5_reg;
            dep6_reg  <= dep5_reg;
        end
    end

    // Center and size divisions
    ssp_pkg::ssp_side_t side_in;
    ssp_pkg::ssp_proj_t proj;
    logic [SIDW-1:0]    side_out;

    assign side_in.visible = vis6_reg;
    assign side_in.neg     = neg6_reg;
    assign side_in.ovf_c   = ovc_reg;
    assign side_in.ovf_s   = ovs_reg;
    assign side_in.depth   = dep6_reg;

    ssp_udiv #(.DW(61), .VW(47), .QW(ssp_pkg::C_QW), .SW(SIDW)) u_div_c (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g6_v_reg),
        .dividend  (nmag6_reg),
        .divisor   (ty6_reg[46:0]),
        .in_side   (side_in),
        .out_valid (proj.valid),
        .quot      (proj.q_c),
        .out_side  (side_out)
    );

    ssp_udiv #(.DW(DSW), .VW(47), .QW(ssp_pkg::C_QW), .SW(1)) u_div_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g6_v_reg),
        .dividend  (ds),
        .divisor   (ty6_reg[46:0]),
        .in_side   (1'b0),
        .out_valid (),
        .quot      (proj.q_s),
        .out_side  ()
    );

    assign proj.side = side_out;

    logic signed [15:0] o_depth;
    logic signed [16:0] o_center, o_fc, o_lc, o_fr, o_lr;
    logic [15:0]        o_size;

    ssp_bounds u_bounds (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .proj          (proj),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (m_tvalid),
        .visible       (m_tuser),
        .depth         (o_depth),
        .center_column (o_center),
        .sprite_size   (o_size),
        .first_column  (o_fc),
        .last_column   (o_lc),
        .first_row     (o_fr),
        .last_row      (o_lr)
    );

    assign m_tdata = {3'b0, o_lr, o_fr, o_lc, o_fc, o_size, o_center, o_depth};

endmodule

/* test/sprite_screen_projection_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for sprite_screen_projection: directed and random sprites,
// several camera settings, random idling on both sides. Depends on ssp_pkg and the RTL.
module sprite_screen_projection_test;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] depth;
        logic signed [16:0] center;
        logic [15:0]        size;
        logic signed [16:0] fcol;
        logic signed [16:0] lcol;
        logic signed [16:0] frow;
        logic signed [16:0] lrow;
    } proj_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ssp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ssp_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    sprite_screen_projection dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // camera state mirrored in the bench
    logic signed [15:0] cam_x, cam_y, dir_x, dir_y, pln_x, pln_y;
    logic [12:0] scr_w, scr_h;

    logic [31:0] sprite_q[$];
    proj_t       proj_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit inputs_done = 0;

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // camera-space transform and screen bounds of one sprite
    function automatic proj_t project(logic signed [15:0] sx, logic signed [15:0] sy);
        longint rx, ry, det, tx, ty, ctr, sz, half, fc, lc, fr, lr, w, h;
        proj_t p;
        w = longint'(scr_w); h = longint'(scr_h);
        rx = longint'(sx) - longint'(cam_x);
        ry = longint'(sy) - longint'(cam_y);
        det = longint'(pln_x) * longint'(dir_y) - longint'(dir_x) * longint'(pln_y);
        tx = 0; ty = 0;
        p.visible = 1'b0;
        if (det != 0) begin
            tx = ((longint'(dir_y) * rx - longint'(dir_x) * ry) * 16384) / det;
            ty = ((longint'(pln_x) * ry - longint'(pln_y) * rx) * 16384) / det;
            p.visible = ty > 0;
        end
        if (p.visible) begin
            ctr = ((w >>> 1) * (ty + tx)) / ty;
            sz = clampv((h * 256) / ty, 0, 65535);
            half = sz >>> 1;
            fc = ctr - half; if (fc < 0) fc = 0;
            lc = ctr + half; if (lc >= w) lc = w - 1;
            fr = (h >>> 1) - half; if (fr < 0) fr = 0;
            lr = (h >>> 1) + half; if (lr >= h) lr = h - 1;
        end else begin
            ctr = 0; sz = 65535; fc = 0; lc = w - 1; fr = 0; lr = h - 1;
        end
        p.depth = 16'(clampv(ty, -32768, 32767));
        p.center = 17'(clampv(ctr, -65536, 65535));
        p.size = 16'(sz);
        p.fcol = 17'(clampv(fc, -65536, 65535));
        p.lcol = 17'(clampv(lc, -65536, 65535));
        p.frow = 17'(clampv(fr, -65536, 65535));
        p.lrow = 17'(clampv(lr, -65536, 65535));
        return p;
    endfunction

    // sprite driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (sprite_q.size() > 0 && (quiet || $urandom_range(99) >= 8)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= sprite_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // expectations are formed when the block takes the sprite
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            proj_q.push_back(project(s_tdata[15:0], s_tdata[31:16]));
    end

    // result monitor
    always @(posedge aclk) begin
        proj_t got, exp_p;
        if (aresetn) begin
            m_tready <= quiet || $urandom_range(99) >= 8;
            if (m_tvalid && m_tready) begin
                got.visible = m_tuser;
                {got.lrow, got.frow, got.lcol, got.fcol, got.size, got.center, got.depth}
                    = m_tdata[116:0];
                if (proj_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected item %h", got);
                end else begin
                    exp_p = proj_q.pop_front();
                    if (got !== exp_p) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %p got %p", exp_p, got);
                    end
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || inputs_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            ssp_pkg::REG_CAMERA_X:     cam_x = val;
            ssp_pkg::REG_CAMERA_Y:     cam_y = val;
            ssp_pkg::REG_VIEW_DIR_X:   dir_x = val;
            ssp_pkg::REG_VIEW_DIR_Y:   dir_y = val;
            ssp_pkg::REG_VIEW_PLANE_X: pln_x = val;
            ssp_pkg::REG_VIEW_PLANE_Y: pln_y = val;
            ssp_pkg::REG_SCREEN_W:     scr_w = val[12:0];
            default:                   scr_h = val[12:0];
        endcase
    endtask

    task automatic set_camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] dx,
                              logic [15:0] dy, logic [15:0] px, logic [15:0] py,
                              logic [12:0] w, logic [12:0] h);
        write_reg(ssp_pkg::REG_CAMERA_X, cx);
        write_reg(ssp_pkg::REG_CAMERA_Y, cy);
        write_reg(ssp_pkg::REG_VIEW_DIR_X, dx);
        write_reg(ssp_pkg::REG_VIEW_DIR_Y, dy);
        write_reg(ssp_pkg::REG_VIEW_PLANE_X, px);
        write_reg(ssp_pkg::REG_VIEW_PLANE_Y, py);
        write_reg(ssp_pkg::REG_SCREEN_W, {3'b0, w});
        write_reg(ssp_pkg::REG_SCREEN_H, {3'b0, h});
    endtask

    // wait for the pipe to drain before touching the camera
    task automatic drain();
        while (sprite_q.size() > 0 || s_tvalid || proj_q.size() > 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // sprites near the camera hit the finite depth range; the rest are anywhere
    task automatic random_sprites(int n);
        logic [15:0] x, y;
        repeat (n) begin
            if ($urandom_range(3) != 0) begin
                x = cam_x + 16'($signed($urandom_range(8191)) - 4096);
                y = cam_y + 16'($signed($urandom_range(8191)) - 4096);
            end else begin
                x = 16'($urandom); y = 16'($urandom);
            end
            sprite_q.push_back({y, x});
        end
    endtask

    initial begin
        cam_x = ssp_pkg::RST_CAMERA_X; cam_y = ssp_pkg::RST_CAMERA_Y;
        dir_x = ssp_pkg::RST_VIEW_DIR_X; dir_y = ssp_pkg::RST_VIEW_DIR_Y;
        pln_x = ssp_pkg::RST_VIEW_PLANE_X; pln_y = ssp_pkg::RST_VIEW_PLANE_Y;
        scr_w = ssp_pkg::RST_SCREEN_W; scr_h = ssp_pkg::RST_SCREEN_H;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset camera, field extremes, sprite on the camera, behind it
        sprite_q.push_back({16'h0000, 16'h0000});
        sprite_q.push_back({16'h7fff, 16'h7fff});
        sprite_q.push_back({16'h8000, 16'h8000});
        sprite_q.push_back({16'h8000, 16'h7fff});
        sprite_q.push_back({16'h0000, 16'h0100});
        sprite_q.push_back({16'h0000, 16'hff00});
        sprite_q.push_back({16'h0080, 16'h0001});
        sprite_q.push_back({16'hff00, 16'h0200});
        sprite_q.push_back({16'h0000, 16'h0001});
        drain();

        // zero determinant
        set_camera(16'h0100, 16'hff00, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 13'd640, 13'd480);
        sprite_q.push_back({16'h1234, 16'h4321});
        sprite_q.push_back({16'hffff, 16'hffff});
        drain();

        // extreme vectors and screen sizes, including out-of-range zero
        set_camera(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                   13'd4096, 13'd4096);
        sprite_q.push_back({16'h7fff, 16'h8000});
        sprite_q.push_back({16'h0000, 16'h0000});
        random_sprites(100);
        drain();
        set_camera(16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0001, 16'h0001, 13'd1, 13'd1);
        random_sprites(100);
        drain();
        set_camera(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h2a3d,
                   13'd0, 13'h1fff);
        random_sprites(50);
        drain();

        // random cameras; one phase without idling
        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 3);
            set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom),
                       13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)));
            random_sprites(110);
            drain();
        end
        quiet = 0;
        inputs_done = 1;
        if (errors == 0 && proj_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ssp_pkg.sv
rtl/ssp_udiv.sv
rtl/ssp_front.sv
rtl/ssp_bounds.sv
rtl/sprite_screen_projection.sv
test/sprite_screen_projection_test.sv
